// ----- hw/rtl/spline_tangent_clamp_assert.svh -----
// ----------------------------------------------------------------------------
// spline_tangent_clamp assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SPLINE_TANGENT_CLAMP_ASSERT_SVH
`define SPLINE_TANGENT_CLAMP_ASSERT_SVH

// Same-cycle implication
`define STC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define STC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and defaults for the clamped spline tangent block.
// ----------------------------------------------------------------------------
package stc_pkg;

  // Default coordinate width (signed Q12.4)
  localparam int COORD_WIDTH_DEF = 16;

  // Operation of the shift-subtract unit
  typedef enum logic {
    STC_OP_SQRT,
    STC_OP_DIV
  } stc_op_t;

  // Command from the sequencer to the shift-subtract unit
  typedef struct packed {
    logic    start;
    stc_op_t op;
  } stc_cmd_t;

endpackage

// ----- hw/rtl/stc_shsub.sv -----
// ----------------------------------------------------------------------------
// stc_shsub
// Shared shift-subtract unit: floor square root or restoring division,
// one result bit per cycle, COORD_WIDTH+1 result bits.
// ----------------------------------------------------------------------------
module stc_shsub #(
  parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stc_pkg::stc_cmd_t          cmd,
  input  logic [2*COORD_WIDTH+1:0]   src,
  input  logic [COORD_WIDTH+1:0]     divisor,
  output logic                       done,
  output logic [COORD_WIDTH:0]       result
);
  import stc_pkg::*;

  localparam int SW  = 2 * COORD_WIDTH + 2;  // operand width
  localparam int RW  = COORD_WIDTH + 1;      // result width, also step count
  localparam int DNW = COORD_WIDTH + 2;      // divisor width
  localparam int UW  = COORD_WIDTH + 5;      // partial remainder working width
  localparam int CW  = $clog2(RW + 1);

  logic [SW-1:0]  src_r,  src_nxt;
  logic [UW-1:0]  rem_r,  rem_nxt;
  logic [RW-1:0]  acc_r,  acc_nxt;
  logic [DNW-1:0] div_r;
  logic [CW-1:0]  cnt_r;
  stc_op_t        op_r;
  logic           busy_r;
  logic           done_r;

  logic [UW-1:0]  shifted;
  logic [UW-1:0]  trial;
  logic [UW:0]    diff;
  logic           fits;

  // Bring in the next operand bits and form the trial subtrahend
  always_comb begin
    unique case (op_r)
      STC_OP_SQRT: begin
        shifted = {rem_r[UW-3:0], src_r[SW-1 -: 2]};
        trial   = {{(UW-RW-2){1'b0}}, acc_r, 2'b01};
        src_nxt = {src_r[SW-3:0], 2'b00};
      end
      STC_OP_DIV: begin
        shifted = {rem_r[UW-2:0], src_r[SW-1]};
        trial   = {{(UW-DNW){1'b0}}, div_r};
        src_nxt = {src_r[SW-2:0], 1'b0};
      end
      default: begin
        shifted = '0;
        trial   = '0;
        src_nxt = src_r;
      end
    endcase
  end

  // One compare-and-subtract decides one result bit
  assign diff    = {1'b0, shifted} - {1'b0, trial};
  assign fits    = !diff[UW];
  assign rem_nxt = fits ? diff[UW-1:0] : shifted;
  assign acc_nxt = {acc_r[RW-2:0], fits};

  // Load on start, step while busy, flag the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !cmd.start && busy_r && (cnt_r == CW'(1));
      if (cmd.start) begin
        op_r   <= cmd.op;
        acc_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= CW'(RW);
        busy_r <= 1'b1;
        if (cmd.op == STC_OP_SQRT) begin
          src_r <= src;
          rem_r <= '0;
        end else begin
          src_r <= {src[RW-1:0], {(SW-RW){1'b0}}};
          rem_r <= UW'(src[SW-1:RW]);
        end
      end else if (busy_r) begin
        src_r <= src_nxt;
        rem_r <= rem_nxt;
        acc_r <= acc_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// ----- hw/rtl/spline_tangent_clamp.sv -----
// ----------------------------------------------------------------------------
// spline_tangent_clamp
// A tangent that needs no shortening does not use the shift-subtract unit;
//   shortening takes two roots and two divisions, one bit per cycle in the
//   shared shift-subtract unit, and the final point adds a zero tangent.
//   One point at a time: in_stall is high until the point's tangents
//   have been loaded into the output register.
// Reset: synchronous, active low; clears the curve history and all control.
// ----------------------------------------------------------------------------
module spline_tangent_clamp #(
  parameter int COORD_WIDTH = stc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic                          in_last_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH:0]   out_tangent_x,
  output logic signed [COORD_WIDTH:0]   out_tangent_y,
  output logic                          out_last_tangent
);
  import stc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;          // difference / tangent width
  localparam int PW = 2 * W + 2;      // square and sum-of-squares width
  localparam int NDIFF = 6;
  localparam logic [1:0] SEEN_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SQR, S_MIN, S_CHK,
    S_RT_GO, S_RT_WAIT, S_RM_GO, S_RM_WAIT,
    S_MX, S_DX_GO, S_DX_WAIT, S_MY, S_DY_GO, S_DY_WAIT,
    S_OUT1, S_OUT2
  } state_t;

  state_t         state_r;
  logic [W-1:0]   prev_x_r, prev_y_r, old_x_r, old_y_r;
  logic [1:0]     seen_r;
  logic           last_r;
  logic           has_first_r;
  logic [DW-1:0]  diff_r [NDIFF];
  logic [2:0]     idx_r;
  logic [PW-1:0]  prod_r, t_sq_r, s0_r, s1_r, min_r;
  logic [DW-1:0]  root_t_r, s_min_r;
  logic [DW-1:0]  res_x_r, res_y_r;
  logic           out_valid_r;
  logic [DW-1:0]  out_x_r, out_y_r;
  logic           out_last_r;

  logic           in_beat;
  logic           out_free;
  logic           out_load;
  logic [2:0]     idx_sel;
  logic [DW-1:0]  mul_a, mul_b;
  logic [PW-1:0]  prod_w;
  stc_cmd_t       unit_cmd;
  logic [PW-1:0]  unit_src;
  logic           unit_done;
  logic [DW-1:0]  unit_res;

  // Magnitude of a two's complement difference (fits unsigned in DW bits)
  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] d);
    mag_of = d[DW-1] ? DW'(~d + DW'(1)) : d;
  endfunction

  // Give a quotient the sign of its tangent component
  function automatic logic [DW-1:0] sign_as(input logic [DW-1:0] d,
                                            input logic [DW-1:0] q);
    sign_as = d[DW-1] ? DW'(~q + DW'(1)) : q;
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // A new output beat enters the output register this cycle
  assign out_load = out_free &&
                    (((state_r == S_OUT1) && has_first_r) || (state_r == S_OUT2));

  // Shared multiplier: squares of the six differences, then |t| * sqrt(min)
  assign idx_sel = (idx_r < 3'(NDIFF)) ? idx_r : 3'd0;

  always_comb begin
    unique case (state_r)
      S_MX: begin
        mul_a = mag_of(diff_r[0]);
        mul_b = s_min_r;
      end
      S_MY: begin
        mul_a = mag_of(diff_r[1]);
        mul_b = s_min_r;
      end
      default: begin
        mul_a = mag_of(diff_r[idx_sel]);
        mul_b = mul_a;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // Command the shift-subtract unit
  always_comb begin
    unit_cmd.start = (state_r == S_RT_GO) || (state_r == S_RM_GO) ||
                     (state_r == S_DX_GO) || (state_r == S_DY_GO);
    unit_cmd.op    = ((state_r == S_RT_GO) || (state_r == S_RM_GO)) ?
                     STC_OP_SQRT : STC_OP_DIV;
    unique case (state_r)
      S_RT_GO: unit_src = t_sq_r;
      S_RM_GO: unit_src = min_r;
      default: unit_src = prod_r;
    endcase
  end

  stc_shsub #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_shsub (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (unit_cmd),
    .src     (unit_src),
    .divisor ({root_t_r, 1'b0}),
    .done    (unit_done),
    .result  (unit_res)
  );

  // Sequencer, curve history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      old_x_r     <= '0;
      old_y_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      last_r      <= 1'b0;
      has_first_r <= 1'b0;
    end else begin
      // drop the output beat once taken, unless a new one loads
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            diff_r[0]   <= {in_point_x[W-1], in_point_x} - {old_x_r[W-1], old_x_r};
            diff_r[1]   <= {in_point_y[W-1], in_point_y} - {old_y_r[W-1], old_y_r};
            diff_r[2]   <= {prev_x_r[W-1], prev_x_r} - {old_x_r[W-1], old_x_r};
            diff_r[3]   <= {prev_y_r[W-1], prev_y_r} - {old_y_r[W-1], old_y_r};
            diff_r[4]   <= {in_point_x[W-1], in_point_x} - {prev_x_r[W-1], prev_x_r};
            diff_r[5]   <= {in_point_y[W-1], in_point_y} - {prev_y_r[W-1], prev_y_r};
            has_first_r <= (seen_r != 2'd0);
            last_r      <= in_last_point;
            res_x_r     <= '0;
            res_y_r     <= '0;
            idx_r       <= '0;
            if (in_last_point) begin
              prev_x_r <= '0;
              prev_y_r <= '0;
              old_x_r  <= '0;
              old_y_r  <= '0;
              seen_r   <= '0;
            end else begin
              old_x_r  <= prev_x_r;
              old_y_r  <= prev_y_r;
              prev_x_r <= in_point_x;
              prev_y_r <= in_point_y;
              seen_r   <= (seen_r == SEEN_FULL) ? SEEN_FULL : seen_r + 2'd1;
            end
            state_r <= (seen_r == SEEN_FULL) ? S_SQR : S_OUT1;
          end
        end

        // square one difference per cycle, accumulate the previous square
        S_SQR: begin
          prod_r <= prod_w;
          idx_r  <= idx_r + 3'd1;
          unique case (idx_r)
            3'd1:    t_sq_r <= prod_r;
            3'd2:    t_sq_r <= t_sq_r + prod_r;
            3'd3:    s0_r   <= prod_r;
            3'd4:    s0_r   <= s0_r + prod_r;
            3'd5:    s1_r   <= prod_r;
            3'd6: begin
              s1_r    <= s1_r + prod_r;
              state_r <= S_MIN;
            end
            default: ;
          endcase
        end

        S_MIN: begin
          min_r   <= (s0_r <= s1_r) ? s0_r : s1_r;
          state_r <= S_CHK;
        end

        // keep the tangent as is when 4*|t|^2 <= min segment length squared
        S_CHK: begin
          if ({t_sq_r, 2'b00} <= {2'b00, min_r}) begin
            res_x_r <= diff_r[0];
            res_y_r <= diff_r[1];
            state_r <= S_OUT1;
          end else begin
            state_r <= S_RT_GO;
          end
        end

        S_RT_GO: state_r <= S_RT_WAIT;

        S_RT_WAIT: begin
          if (unit_done) begin
            root_t_r <= unit_res;
            state_r  <= S_RM_GO;
          end
        end

        S_RM_GO: state_r <= S_RM_WAIT;

        S_RM_WAIT: begin
          if (unit_done) begin
            s_min_r <= unit_res;
            state_r <= S_MX;
          end
        end

        S_MX: begin
          prod_r  <= prod_w;
          state_r <= S_DX_GO;
        end

        S_DX_GO: state_r <= S_DX_WAIT;

        S_DX_WAIT: begin
          if (unit_done) begin
            res_x_r <= sign_as(diff_r[0], unit_res);
            state_r <= S_MY;
          end
        end

        S_MY: begin
          prod_r  <= prod_w;
          state_r <= S_DY_GO;
        end

        S_DY_GO: state_r <= S_DY_WAIT;

        S_DY_WAIT: begin
          if (unit_done) begin
            res_y_r <= sign_as(diff_r[1], unit_res);
            state_r <= S_OUT1;
          end
        end

        // tangent of the point before this one, if there is one
        S_OUT1: begin
          if (!has_first_r) begin
            state_r <= last_r ? S_OUT2 : S_IDLE;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_last_r  <= 1'b0;
            state_r     <= last_r ? S_OUT2 : S_IDLE;
          end
        end

        // zero tangent of the final point
        S_OUT2: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tangent_x    = out_x_r;
  assign out_tangent_y    = out_y_r;
  assign out_last_tangent = out_last_r;

  `include "spline_tangent_clamp_assert.svh"

  `STC_ASSERT_NEXT(a_last_clears_history, in_beat && in_last_point, seen_r == 2'd0, "history not cleared after final point")
  `STC_ASSERT_NOW(a_seen_saturates, 1'b1, seen_r != 2'd3, "point count past saturation")
  `STC_ASSERT_NOW(a_done_while_waiting, unit_done, state_r == S_RT_WAIT || state_r == S_RM_WAIT || state_r == S_DX_WAIT || state_r == S_DY_WAIT, "unit finished outside a wait state")
  `STC_ASSERT_NEXT(a_final_beat_loaded, state_r == S_OUT2 && out_free, out_valid && out_last_tangent && state_r == S_IDLE, "final tangent beat not loaded")

endmodule

// ----- tb/sv/spline_tangent_clamp_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_tangent_clamp_tb
// Self-checking bench for the clamped spline tangent block. A table of
// directed curves (extremes, short curves, repeated points, sharp turns)
// is followed by random curves. Every accepted point is run through a
// behavioural tangent predictor, and each output beat is compared with the
// oldest expected tangent. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module spline_tangent_clamp_tb;

  localparam int CW             = stc_pkg::COORD_WIDTH_DEF;
  localparam int DIR_ROWS       = 23;
  localparam int RANDOM_ITEMS   = 850;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 200;
  localparam int CALM_FROM      = DIR_ROWS + 300;
  localparam int CALM_TO        = DIR_ROWS + 420;
  localparam int DRAIN_AT       = DIR_ROWS + 500;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } point_t;

  typedef struct {
    logic signed [CW:0] tx;
    logic signed [CW:0] ty;
    logic               last;
  } tangent_t;

  // One directed or random point; typed_n < 0 means "use the predictor"
  typedef struct {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 last;
    int                   typed_n;
    tangent_t             r0;
    tangent_t             r1;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] in_point_x = '0;
  logic signed [CW-1:0] in_point_y = '0;
  logic                 in_last_point = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW:0]   out_tangent_x;
  logic signed [CW:0]   out_tangent_y;
  logic                 out_last_tangent;

  // Predictor state: curve history
  point_t     prev_pt = '{0, 0};
  point_t     older_pt = '{0, 0};
  logic [1:0] pts_seen = 2'd0;

  // Stimulus-side history for shaping random curves
  point_t     gen_prev = '{0, 0};
  point_t     gen_older = '{0, 0};

  tangent_t   tangent_q [$];
  stim_row_t  cur_row;
  int         err_count = 0;
  int         items_sent = 0;
  int         idle_cycles = 0;
  int         stall_run = 0;
  bit         calm = 1'b0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // single-point curve straight after reset
    '{0, 0, 1, 1, '{0, 0, 1}, '{0, 0, 0}},
    // two-point curve at opposite corners
    '{32767, -32768, 0, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{-32768, 32767, 1, 2, '{0, 0, 0}, '{0, 0, 1}},
    // corner to corner, full-scale differences
    '{-32768, -32768, 0, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{32767, 32767, 0, 1, '{0, 0, 0}, '{0, 0, 0}},
    '{-32768, -32768, 0, -1, '{0, 0, 0}, '{0, 0, 0}},
    '{32767, -32768, 0, -1, '{0, 0, 0}, '{0, 0, 0}},
    '{-32768, 32767, 0, -1, '{0, 0, 0}, '{0, 0, 0}},
    '{32767, 32767, 1, -1, '{0, 0, 0}, '{0, 0, 0}},
    // repeated points force zero tangents
    '{100, 50, 0, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{100, 50, 0, 1, '{0, 0, 0}, '{0, 0, 0}},
    '{300, -20, 0, 1, '{0, 0, 0}, '{0, 0, 0}},
    '{300, -20, 1, 2, '{0, 0, 0}, '{0, 0, 1}},
    // sharp turns back: short tangents pass unchanged
    '{0, 0, 0, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{1600, 0, 0, 1, '{0, 0, 0}, '{0, 0, 0}},
    '{160, 0, 0, -1, '{0, 0, 0}, '{0, 0, 0}},
    '{-800, 400, 0, -1, '{0, 0, 0}, '{0, 0, 0}},
    '{-801, -399, 0, -1, '{0, 0, 0}, '{0, 0, 0}},
    '{5, -7, 1, -1, '{0, 0, 0}, '{0, 0, 0}},
    // evenly spaced line: every inner tangent is shortened
    '{0, 0, 0, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{16, 0, 0, 1, '{0, 0, 0}, '{0, 0, 0}},
    '{32, 0, 0, -1, '{0, 0, 0}, '{0, 0, 0}},
    '{48, 0, 1, -1, '{0, 0, 0}, '{0, 0, 0}}
  };

  spline_tangent_clamp #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tangent_x   (out_tangent_x),
    .out_tangent_y   (out_tangent_y),
    .out_last_tangent(out_last_tangent)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Tangent predictor
  // --------------------------------------------------------------------------
  function automatic logic [127:0] magnitude(input logic signed [CW:0] v);
    logic [CW:0] m;
    m = v[CW] ? -v : v;
    return 128'(m);
  endfunction

  function automatic logic [127:0] sq_len(input logic signed [CW:0] x,
                                          input logic signed [CW:0] y);
    return magnitude(x) * magnitude(x) + magnitude(y) * magnitude(y);
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // Scale one component by root_min / den, truncating toward zero
  function automatic logic signed [CW:0] scale_toward_zero(input logic signed [CW:0] v,
                                                           input logic [127:0] root_min,
                                                           input logic [127:0] den);
    logic [127:0] q;
    q = magnitude(v) * root_min / den;
    return v[CW] ? -(q[CW:0]) : q[CW:0];
  endfunction

  function automatic tangent_t clamped_tangent(input point_t a, input point_t b,
                                               input point_t c);
    logic signed [CW:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic [127:0]       t_sq, s0, s1, min_sq, den, root_min;
    tangent_t           r;
    ax = a.x; ay = a.y; bx = b.x; by = b.y; cx = c.x; cy = c.y;
    dx = cx - ax;
    dy = cy - ay;
    t_sq = sq_len(dx, dy);
    s0 = sq_len(bx - ax, by - ay);
    s1 = sq_len(cx - bx, cy - by);
    min_sq = (s0 <= s1) ? s0 : s1;
    r.last = 1'b0;
    if ((t_sq << 2) <= min_sq) begin
      r.tx = dx;
      r.ty = dy;
    end else begin
      den = 2 * floor_sqrt(t_sq);
      root_min = floor_sqrt(min_sq);
      r.tx = scale_toward_zero(dx, root_min, den);
      r.ty = scale_toward_zero(dy, root_min, den);
    end
    return r;
  endfunction

  // Advance the curve history by one point; return the tangents it releases
  function automatic int advance_curve(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y,
                                       input logic last, output tangent_t res [2]);
    point_t p;
    int     n;
    p.x = x;
    p.y = y;
    n = 0;
    res[0] = '{0, 0, 0};
    res[1] = '{0, 0, 0};
    if (pts_seen == 2'd1) begin
      n++;
    end else if (pts_seen >= 2'd2) begin
      res[n] = clamped_tangent(older_pt, prev_pt, p);
      n++;
    end
    if (last) begin
      res[n] = '{0, 0, 1};
      n++;
      prev_pt = '{0, 0};
      older_pt = '{0, 0};
      pts_seen = 2'd0;
    end else begin
      older_pt = prev_pt;
      prev_pt = p;
      if (pts_seen < 2'd2) pts_seen++;
    end
    return n;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on input beats, check output beats, watch for hangs
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    int       n;
    tangent_t res [2];
    tangent_t want;
    bit       moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        n = advance_curve(in_point_x, in_point_y, in_last_point, res);
        if (cur_row.typed_n >= 0) begin
          if (cur_row.typed_n > 0) tangent_q.push_back(cur_row.r0);
          if (cur_row.typed_n > 1) tangent_q.push_back(cur_row.r1);
        end else begin
          for (int i = 0; i < n; i++) tangent_q.push_back(res[i]);
        end
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (tangent_q.size() == 0) begin
          flag_error($sformatf("unexpected tangent (%0d,%0d) last=%0b",
                               out_tangent_x, out_tangent_y, out_last_tangent));
        end else begin
          want = tangent_q.pop_front();
          if (out_tangent_x !== want.tx || out_tangent_y !== want.ty ||
              out_last_tangent !== want.last)
            flag_error($sformatf("tangent got (%0d,%0d,%0b) want (%0d,%0d,%0b)",
                                 out_tangent_x, out_tangent_y, out_last_tangent,
                                 want.tx, want.ty, want.last));
        end
      end
      // End the run if nothing moves for too long
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall in short bursts, none during the calm stretch
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_run == 0 && !calm && $urandom_range(99) == 0)
      stall_run = $urandom_range(1, 11);
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Present one point, hold it until accepted, then maybe idle a while
  task automatic send_point(input stim_row_t row);
    in_valid      <= 1'b1;
    in_point_x    <= row.px;
    in_point_y    <= row.py;
    in_last_point <= row.last;
    cur_row       <= row;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
    calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
  endtask

  // Hold off until every predicted tangent has come out
  task automatic drain_tangents();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tangent_q.size() != 0) @(posedge clk);
  endtask

  function automatic int jitter(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic signed [CW-1:0] extreme_coord();
    case ($urandom_range(3))
      0:       return {1'b1, {(CW-1){1'b0}}};
      1:       return {1'b0, {(CW-1){1'b1}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // One random curve: mix of wild, nearby, repeated, turning-back and corner points
  task automatic send_random_curve(input int len);
    stim_row_t row;
    int        mode;
    row.typed_n = -1;
    row.r0 = '{0, 0, 0};
    row.r1 = '{0, 0, 0};
    for (int i = 0; i < len; i++) begin
      mode = $urandom_range(99);
      if (mode < 30) begin
        row.px = CW'($urandom);
        row.py = CW'($urandom);
      end else if (mode < 65) begin
        row.px = CW'(gen_prev.x + jitter(256));
        row.py = CW'(gen_prev.y + jitter(256));
      end else if (mode < 75) begin
        row.px = gen_prev.x;
        row.py = gen_prev.y;
      end else if (mode < 90) begin
        row.px = CW'(gen_older.x + jitter(32));
        row.py = CW'(gen_older.y + jitter(32));
      end else begin
        row.px = extreme_coord();
        row.py = extreme_coord();
      end
      row.last = (i == len - 1);
      send_point(row);
      gen_older = gen_prev;
      gen_prev = '{row.px, row.py};
    end
  endtask

  initial begin : driver
    int  len;
    int  pick;
    bit  drained;
    drained = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) send_point(dir_rows[i]);
    drain_tangents();

    // Random curves, mostly a handful of points long
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10)      len = 1;
      else if (pick < 20) len = 2;
      else                len = $urandom_range(3, 12);
      send_random_curve(len);
      if (!drained && items_sent >= DRAIN_AT) begin
        drain_tangents();
        drained = 1'b1;
      end
    end

    // Wait for the last tangents, then a quiet tail
    in_valid <= 1'b0;
    @(posedge clk);
    while (tangent_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
